/* rtl/core/ppa_pkg.sv */
// ----------------------------------------------------------------------------
// ppa_pkg
// Shared types and constants for the particle pool ager: field widths, the
// stored particle record and the result of one slot update.
// ----------------------------------------------------------------------------
package ppa_pkg;

   // pool depth default
   localparam int PPA_POOL_SIZE = 64;

   // field widths
   localparam int POS_W    = 16;   // Q12.4 position and velocity
   localparam int HALF_W   = 12;   // Q8.4 half edge
   localparam int LIFE_W   = 16;   // ticks to live
   localparam int EDGE_W   = 17;   // Q13.4 quad edge
   localparam int SCREEN_W = 11;   // screen size, whole pixels
   localparam int SLOT_W   = 6;    // slot field of a result
   localparam int FRAC_W   = 4;    // fraction bits of the fixed point

   // one stored particle
   typedef struct packed {
      logic signed [POS_W-1:0]  pos_x;
      logic signed [POS_W-1:0]  pos_y;
      logic signed [POS_W-1:0]  vel_x;
      logic signed [POS_W-1:0]  vel_y;
      logic        [HALF_W-1:0] half;
      logic        [LIFE_W-1:0] life;
   } particle_type;

   localparam int PARTICLE_W = $bits(particle_type);

   // outcome of updating one live slot
   typedef struct packed {
      particle_type next;
      logic         survive;
   } upd_type;

endpackage

/* rtl/core/ppa_ram.sv */
// ----------------------------------------------------------------------------
// ppa_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module ppa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/ppa_update.sv */
// ----------------------------------------------------------------------------
// ppa_update
// Slot update unit, shared by every slot of a tick sweep: saturating
// position step, life countdown and screen bounds check.
// ----------------------------------------------------------------------------
module ppa_update (
   input  ppa_pkg::particle_type          cur,
   input  logic [ppa_pkg::SCREEN_W-1:0]   width_px,
   input  logic [ppa_pkg::SCREEN_W-1:0]   height_px,
   output ppa_pkg::upd_type               result
);

   import ppa_pkg::*;

   localparam int LIM_W = SCREEN_W + FRAC_W;

   logic signed [POS_W:0]   sum_x;
   logic signed [POS_W:0]   sum_y;
   logic signed [POS_W-1:0] new_x;
   logic signed [POS_W-1:0] new_y;
   logic [LIM_W-1:0]        lim_x;
   logic [LIM_W-1:0]        lim_y;
   logic                    life_out;
   logic                    off_x;
   logic                    off_y;

   // position step, one guard bit for the saturation test
   assign sum_x = {cur.pos_x[POS_W-1], cur.pos_x} + {cur.vel_x[POS_W-1], cur.vel_x};
   assign sum_y = {cur.pos_y[POS_W-1], cur.pos_y} + {cur.vel_y[POS_W-1], cur.vel_y};

   always_comb begin
      if (sum_x[POS_W] != sum_x[POS_W-1]) begin
         new_x = sum_x[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
      end else begin
         new_x = sum_x[POS_W-1:0];
      end
      if (sum_y[POS_W] != sum_y[POS_W-1]) begin
         new_y = sum_y[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
      end else begin
         new_y = sum_y[POS_W-1:0];
      end
   end

   // life of zero or one runs out now and stays at zero
   assign life_out = (cur.life[LIFE_W-1:1] == '0);

   // bounds: negative, or beyond the edge in Q.4; the border itself survives
   assign lim_x = {width_px,  {FRAC_W{1'b0}}};
   assign lim_y = {height_px, {FRAC_W{1'b0}}};
   assign off_x = new_x[POS_W-1] || (LIM_W'(new_x[POS_W-2:0]) > lim_x);
   assign off_y = new_y[POS_W-1] || (LIM_W'(new_y[POS_W-2:0]) > lim_y);

   always_comb begin
      result.next       = cur;
      result.next.pos_x = new_x;
      result.next.pos_y = new_y;
      result.next.life  = life_out ? '0 : cur.life - LIFE_W'(1);
      result.survive    = !(life_out || off_x || off_y);
   end

endmodule

/* rtl/core/particle_pool_ager.sv */
// ----------------------------------------------------------------------------
// particle_pool_ager
// Fixed pool of 2D particles. A spawn fills the lowest free slot; a tick
// moves every live particle, ages it, retires it and reports each survivor's
// bounding quad.
//
//   channel   ports          transfer
//   --------  -------------  ---------------------------------------------
//   request   start, req_*   taken when start is high and busy is low
//   response  rsp_*          one per spawn, one per tick survivor, marked by rsp_strobe
//   control   csr_*          write taken when csr_we is high
//
// A spawn scans the alive flags one slot a cycle, then gives its answer.
// A tick streams every slot through the update unit from the particle RAM,
// one RAM read per cycle. busy is high from acceptance until the final
// response has been issued.
// Reset clears the alive flags and loads a 1280 x 720 screen; the particle
// RAM holds no reset and needs no clearing pass. The receiver cannot stall.
// ----------------------------------------------------------------------------
module particle_pool_ager #(
   parameter int POOL_SIZE = ppa_pkg::PPA_POOL_SIZE
) (
   input  logic                                clock,
   input  logic                                reset,
   // request
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_op,
   input  logic signed [ppa_pkg::POS_W-1:0]    req_start_x,
   input  logic signed [ppa_pkg::POS_W-1:0]    req_start_y,
   input  logic signed [ppa_pkg::POS_W-1:0]    req_speed_x,
   input  logic signed [ppa_pkg::POS_W-1:0]    req_speed_y,
   input  logic        [ppa_pkg::HALF_W-1:0]   req_size_in,
   input  logic        [ppa_pkg::LIFE_W-1:0]   req_life_in,
   // response
   output logic                                rsp_strobe,
   output logic                                rsp_kind,
   output logic                                rsp_accepted,
   output logic        [ppa_pkg::SLOT_W-1:0]   rsp_slot,
   output logic signed [ppa_pkg::EDGE_W-1:0]   rsp_left,
   output logic signed [ppa_pkg::EDGE_W-1:0]   rsp_top,
   output logic signed [ppa_pkg::EDGE_W-1:0]   rsp_right,
   output logic signed [ppa_pkg::EDGE_W-1:0]   rsp_bottom,
   output logic                                rsp_last,
   // control registers
   input  logic                                csr_we,
   input  logic                                csr_index,
   input  logic        [ppa_pkg::SCREEN_W-1:0] csr_wdata
);

   import ppa_pkg::*;

   localparam int IDX_W = $clog2(POOL_SIZE);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(POOL_SIZE - 1);

   // sequencer states
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SPAWN  = 3'd1;
   localparam logic [2:0] ST_SWEEP  = 3'd2;
   localparam logic [2:0] ST_FLUSH  = 3'd3;
   localparam logic [2:0] ST_FINISH = 3'd4;

   // operations and register indexes
   localparam logic OP_SPAWN = 1'b0;
   localparam logic OP_TICK  = 1'b1;
   localparam logic CSR_SCREEN_WIDTH  = 1'b0;
   localparam logic CSR_SCREEN_HEIGHT = 1'b1;

   // result kinds
   localparam logic KIND_SPAWN = 1'b0;
   localparam logic KIND_QUAD  = 1'b1;

   logic [2:0]          state_ff,  state_in;
   logic [IDX_W-1:0]    idx_ff,    idx_in;
   logic                alive_ff [POOL_SIZE];
   logic [SCREEN_W-1:0] width_ff;
   logic [SCREEN_W-1:0] height_ff;
   particle_type        spawn_ff;

   // update stage
   logic                s1_valid_ff;
   logic                s1_live_ff;
   logic [IDX_W-1:0]    s1_slot_ff;

   // held survivor, released once the next one (or the sweep end) is known
   logic                pend_valid_ff;
   logic [IDX_W-1:0]    pend_slot_ff;
   particle_type        pend_ff;

   // response registers
   logic                    rsp_strobe_ff;
   logic                    rsp_kind_ff;
   logic                    rsp_accepted_ff;
   logic [SLOT_W-1:0]       rsp_slot_ff;
   logic signed [EDGE_W-1:0] rsp_left_ff;
   logic signed [EDGE_W-1:0] rsp_top_ff;
   logic signed [EDGE_W-1:0] rsp_right_ff;
   logic signed [EDGE_W-1:0] rsp_bottom_ff;
   logic                    rsp_last_ff;

   logic                accept;
   logic                idx_alive;
   logic                spawn_hit;
   logic                spawn_miss;
   logic                upd_fire;
   logic                emit_mid;
   logic                emit_end;
   logic                ram_we;
   logic [IDX_W-1:0]    ram_waddr;
   particle_type        ram_wdata;
   particle_type        ram_rdata;
   upd_type             upd;

   logic signed [EDGE_W-1:0] px_ext;
   logic signed [EDGE_W-1:0] py_ext;
   logic signed [EDGE_W-1:0] r_ext;

   assign accept    = start && (state_ff == ST_IDLE);
   assign busy      = (state_ff != ST_IDLE);
   assign idx_alive = alive_ff[idx_ff];
   assign spawn_hit  = (state_ff == ST_SPAWN) && !idx_alive;
   assign spawn_miss = (state_ff == ST_SPAWN) && idx_alive && (idx_ff == IDX_LAST);
   assign upd_fire  = s1_valid_ff && s1_live_ff;
   assign emit_mid  = upd_fire && upd.survive && pend_valid_ff;
   assign emit_end  = (state_ff == ST_FINISH) && pend_valid_ff;

   // particle store
   ppa_ram #(
      .WIDTH (PARTICLE_W),
      .DEPTH (POOL_SIZE)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (idx_ff),
      .rd_data (ram_rdata)
   );

   // shared update unit
   ppa_update u_update (
      .cur       (ram_rdata),
      .width_px  (width_ff),
      .height_px (height_ff),
      .result    (upd)
   );

   // RAM write: spawn fill or tick write-back, never both at once
   always_comb begin
      ram_we    = spawn_hit || upd_fire;
      ram_waddr = spawn_hit ? idx_ff : s1_slot_ff;
      ram_wdata = spawn_hit ? spawn_ff : upd.next;
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            idx_in = '0;
            if (accept) begin
               state_in = (req_op == OP_SPAWN) ? ST_SPAWN : ST_SWEEP;
            end
         end
         ST_SPAWN: begin
            if (spawn_hit || spawn_miss) begin
               state_in = ST_IDLE;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         ST_SWEEP: begin
            if (idx_ff == IDX_LAST) begin
               state_in = ST_FLUSH;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         ST_FLUSH:  state_in = ST_FINISH;
         ST_FINISH: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= SCREEN_W'(1280);
         height_ff <= SCREEN_W'(720);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SCREEN_WIDTH:  width_ff  <= csr_wdata;
            CSR_SCREEN_HEIGHT: height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // spawn payload, captured with the transaction
   always_ff @(posedge clock) begin
      if (accept) begin
         spawn_ff.pos_x <= req_start_x;
         spawn_ff.pos_y <= req_start_y;
         spawn_ff.vel_x <= req_speed_x;
         spawn_ff.vel_y <= req_speed_y;
         spawn_ff.half  <= req_size_in;
         spawn_ff.life  <= req_life_in;
      end
   end

   // alive flags: set by a spawn, cleared when a particle dies
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < POOL_SIZE; i++) begin
            alive_ff[i] <= 1'b0;
         end
      end else begin
         if (spawn_hit) begin
            alive_ff[idx_ff] <= 1'b1;
         end
         if (upd_fire && !upd.survive) begin
            alive_ff[s1_slot_ff] <= 1'b0;
         end
      end
   end

   // update stage, aligned with the RAM read data
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= (state_ff == ST_SWEEP);
      end
   end

   always_ff @(posedge clock) begin
      s1_live_ff <= idx_alive;
      s1_slot_ff <= idx_ff;
   end

   // held survivor
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
      end else if (upd_fire && upd.survive) begin
         pend_valid_ff <= 1'b1;
      end else if (state_ff == ST_FINISH) begin
         pend_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (upd_fire && upd.survive) begin
         pend_ff      <= upd.next;
         pend_slot_ff <= s1_slot_ff;
      end
   end

   // quad edges of the held survivor
   assign px_ext = EDGE_W'(pend_ff.pos_x);
   assign py_ext = EDGE_W'(pend_ff.pos_y);
   assign r_ext  = $signed({{(EDGE_W-HALF_W){1'b0}}, pend_ff.half});

   // response registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= spawn_hit || spawn_miss || emit_mid || emit_end;
      end
   end

   always_ff @(posedge clock) begin
      if (spawn_hit || spawn_miss) begin
         rsp_kind_ff     <= KIND_SPAWN;
         rsp_accepted_ff <= spawn_hit;
         rsp_slot_ff     <= spawn_hit ? SLOT_W'(idx_ff) : '0;
         rsp_left_ff     <= '0;
         rsp_top_ff      <= '0;
         rsp_right_ff    <= '0;
         rsp_bottom_ff   <= '0;
         rsp_last_ff     <= 1'b1;
      end else if (emit_mid || emit_end) begin
         rsp_kind_ff     <= KIND_QUAD;
         rsp_accepted_ff <= 1'b0;
         rsp_slot_ff     <= SLOT_W'(pend_slot_ff);
         rsp_left_ff     <= px_ext - r_ext;
         rsp_top_ff      <= py_ext - r_ext;
         rsp_right_ff    <= px_ext + r_ext;
         rsp_bottom_ff   <= py_ext + r_ext;
         rsp_last_ff     <= emit_end;
      end
   end

   assign rsp_strobe   = rsp_strobe_ff;
   assign rsp_kind     = rsp_kind_ff;
   assign rsp_accepted = rsp_accepted_ff;
   assign rsp_slot     = rsp_slot_ff;
   assign rsp_left     = rsp_left_ff;
   assign rsp_top      = rsp_top_ff;
   assign rsp_right    = rsp_right_ff;
   assign rsp_bottom   = rsp_bottom_ff;
   assign rsp_last     = rsp_last_ff;

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for particle_pool_ager. It drives spawn and tick transactions
// over the start/busy handshake and keeps its own copy of the particle pool.
// Every response transaction is checked against that copy, field by field.
// A directed script covers the edges, then random phases follow, each under
// its own screen size.
// ----------------------------------------------------------------------------
module tb;
   import ppa_pkg::*;

   localparam int POOL          = PPA_POOL_SIZE;
   localparam int CLOCK_PERIOD  = 12;
   localparam int SETTLE_CYCLES = POOL + 16;    // a full tick sweep and some
   localparam int RANDOM_PHASES = 5;
   localparam int PHASE_ITEMS   = 84;
   localparam int POS_MAX       = 2 ** (POS_W - 1) - 1;
   localparam int POS_MIN       = -(2 ** (POS_W - 1));

   localparam logic OP_SPAWN          = 1'b0;
   localparam logic OP_TICK           = 1'b1;
   localparam logic KIND_SPAWN        = 1'b0;
   localparam logic KIND_QUAD         = 1'b1;
   localparam logic REG_SCREEN_WIDTH  = 1'b0;
   localparam logic REG_SCREEN_HEIGHT = 1'b1;

   typedef struct packed {
      logic                     op;
      logic signed [POS_W-1:0]  start_x;
      logic signed [POS_W-1:0]  start_y;
      logic signed [POS_W-1:0]  speed_x;
      logic signed [POS_W-1:0]  speed_y;
      logic        [HALF_W-1:0] size_in;
      logic        [LIFE_W-1:0] life_in;
   } pool_request_type;

   typedef struct packed {
      logic                     kind;
      logic                     accepted;
      logic        [SLOT_W-1:0] slot;
      logic signed [EDGE_W-1:0] left;
      logic signed [EDGE_W-1:0] top;
      logic signed [EDGE_W-1:0] right;
      logic signed [EDGE_W-1:0] bottom;
      logic                     last;
   } pool_answer_type;

   // one line of the directed script: a register write or a repeated request
   typedef struct packed {
      logic                  is_csr;
      logic                  csr_idx;
      logic [SCREEN_W-1:0]   csr_val;
      pool_request_type      req;
      logic [6:0]            repeats;
      logic                  typed;
      logic                  typed_acc;
      logic [SLOT_W-1:0]     typed_slot;
   } script_row_type;

   logic                     clock;
   logic                     reset;
   logic                     start;
   logic                     busy;
   logic                     req_op;
   logic signed [POS_W-1:0]  req_start_x;
   logic signed [POS_W-1:0]  req_start_y;
   logic signed [POS_W-1:0]  req_speed_x;
   logic signed [POS_W-1:0]  req_speed_y;
   logic        [HALF_W-1:0] req_size_in;
   logic        [LIFE_W-1:0] req_life_in;
   logic                     rsp_strobe;
   logic                     rsp_kind;
   logic                     rsp_accepted;
   logic        [SLOT_W-1:0] rsp_slot;
   logic signed [EDGE_W-1:0] rsp_left;
   logic signed [EDGE_W-1:0] rsp_top;
   logic signed [EDGE_W-1:0] rsp_right;
   logic signed [EDGE_W-1:0] rsp_bottom;
   logic                     rsp_last;
   logic                     csr_we;
   logic                     csr_index;
   logic      [SCREEN_W-1:0] csr_wdata;

   // shadow of the pool
   bit  live      [POOL];
   int  pos_x     [POOL];
   int  pos_y     [POOL];
   int  vel_x     [POOL];
   int  vel_y     [POOL];
   int  half_edge [POOL];
   int  life_left [POOL];
   int  screen_w;
   int  screen_h;

   pool_answer_type expected_answers[$];
   script_row_type  script [32];
   int              script_len;
   int              error_count;
   bit              gaps_on;

   particle_pool_ager #(.POOL_SIZE(POOL)) dut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_op       (req_op),
      .req_start_x  (req_start_x),
      .req_start_y  (req_start_y),
      .req_speed_x  (req_speed_x),
      .req_speed_y  (req_speed_y),
      .req_size_in  (req_size_in),
      .req_life_in  (req_life_in),
      .rsp_strobe   (rsp_strobe),
      .rsp_kind     (rsp_kind),
      .rsp_accepted (rsp_accepted),
      .rsp_slot     (rsp_slot),
      .rsp_left     (rsp_left),
      .rsp_top      (rsp_top),
      .rsp_right    (rsp_right),
      .rsp_bottom   (rsp_bottom),
      .rsp_last     (rsp_last),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   initial clock = 1'b0;
   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // hard stop well beyond the slowest legal run
   initial begin
      #(CLOCK_PERIOD * 800000);
      $display("FAILURE");
      $finish;
   end

   function automatic int clamp16(input int v);
      if (v > POS_MAX) return POS_MAX;
      if (v < POS_MIN) return POS_MIN;
      return v;
   endfunction

   // advance the shadow pool by one request and queue its answers
   task automatic pool_step(input pool_request_type r);
      int              free_slot;
      int              nx;
      int              ny;
      bit              dead;
      bit              have_held;
      pool_answer_type ans;
      pool_answer_type held;
      ans       = '0;
      held      = '0;
      have_held = 1'b0;
      free_slot = -1;
      if (r.op == OP_SPAWN) begin
         // lowest free slot wins
         for (int i = POOL - 1; i >= 0; i--)
            if (!live[i]) free_slot = i;
         ans.kind = KIND_SPAWN;
         ans.last = 1'b1;
         if (free_slot >= 0) begin
            live[free_slot]      = 1'b1;
            pos_x[free_slot]     = int'(r.start_x);
            pos_y[free_slot]     = int'(r.start_y);
            vel_x[free_slot]     = int'(r.speed_x);
            vel_y[free_slot]     = int'(r.speed_y);
            half_edge[free_slot] = int'(r.size_in);
            life_left[free_slot] = int'(r.life_in);
            ans.accepted         = 1'b1;
            ans.slot             = SLOT_W'(free_slot);
         end
         expected_answers.push_back(ans);
      end else begin
         // sweep live slots in order; hold one quad back to mark the last
         for (int i = 0; i < POOL; i++) begin
            if (live[i]) begin
               nx = clamp16(pos_x[i] + vel_x[i]);
               ny = clamp16(pos_y[i] + vel_y[i]);
               pos_x[i] = nx;
               pos_y[i] = ny;
               dead = (life_left[i] <= 1);
               life_left[i] = dead ? 0 : life_left[i] - 1;
               if (nx < 0 || nx > screen_w * 16 || ny < 0 || ny > screen_h * 16)
                  dead = 1'b1;
               if (dead) begin
                  live[i] = 1'b0;
               end else begin
                  if (have_held) expected_answers.push_back(held);
                  held        = '0;
                  held.kind   = KIND_QUAD;
                  held.slot   = SLOT_W'(i);
                  held.left   = EDGE_W'(nx - half_edge[i]);
                  held.top    = EDGE_W'(ny - half_edge[i]);
                  held.right  = EDGE_W'(nx + half_edge[i]);
                  held.bottom = EDGE_W'(ny + half_edge[i]);
                  have_held   = 1'b1;
               end
            end
         end
         if (have_held) begin
            held.last = 1'b1;
            expected_answers.push_back(held);
         end
      end
   endtask

   function automatic int pick_gap();
      int roll;
      if (!gaps_on) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 4);
      return $urandom_range(10, 60);
   endfunction

   function automatic logic signed [POS_W-1:0] random_speed();
      int roll;
      int v;
      roll = $urandom_range(0, 9);
      if (roll < 7) begin
         v = $urandom_range(0, 64);
         return POS_W'(v - 32);
      end
      if (roll < 9) begin
         v = $urandom_range(0, 512);
         return POS_W'(v - 256);
      end
      return POS_W'($urandom);
   endfunction

   function automatic logic signed [POS_W-1:0] random_position(input int span);
      if ($urandom_range(0, 9) < 8) return POS_W'($urandom_range(0, span * 16));
      return POS_W'($urandom);
   endfunction

   function automatic pool_request_type random_request(input int tick_pct);
      pool_request_type r;
      int               roll;
      r.op      = ($urandom_range(0, 99) < tick_pct) ? OP_TICK : OP_SPAWN;
      r.start_x = random_position(screen_w);
      r.start_y = random_position(screen_h);
      r.speed_x = random_speed();
      r.speed_y = random_speed();
      r.size_in = HALF_W'($urandom);
      roll = $urandom_range(0, 19);
      if (roll < 10)      r.life_in = LIFE_W'($urandom_range(1, 30));
      else if (roll < 13) r.life_in = LIFE_W'($urandom_range(0, 2));
      else if (roll < 18) r.life_in = LIFE_W'($urandom_range(30, 300));
      else                r.life_in = LIFE_W'($urandom);
      return r;
   endfunction

   // present one request, wait for it to be taken, then predict its answers
   task automatic send_request(input pool_request_type r, input bit typed,
                               input pool_answer_type typed_answer);
      int gap;
      start       = 1'b1;
      req_op      = r.op;
      req_start_x = r.start_x;
      req_start_y = r.start_y;
      req_speed_x = r.speed_x;
      req_speed_y = r.speed_y;
      req_size_in = r.size_in;
      req_life_in = r.life_in;
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
      pool_step(r);
      if (typed) begin
         void'(expected_answers.pop_back());
         expected_answers.push_back(typed_answer);
      end
      gap = pick_gap();
      if (gap > 0) begin
         start = 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // hold off until every answer is in and the last sweep has finished
   task automatic settle_pool();
      start = 1'b0;
      while (expected_answers.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      while (busy) @(negedge clock);
   endtask

   task automatic write_screen(input logic idx, input int value);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = SCREEN_W'(value);
      @(negedge clock);
      csr_we = 1'b0;
      if (idx == REG_SCREEN_WIDTH) screen_w = value;
      else                         screen_h = value;
   endtask

   task automatic add_item(input logic op, input int sx, input int sy, input int vx,
                           input int vy, input int size, input int life, input int reps,
                           input bit typed, input bit acc, input int slot);
      script_row_type row;
      row             = '0;
      row.req.op      = op;
      row.req.start_x = POS_W'(sx);
      row.req.start_y = POS_W'(sy);
      row.req.speed_x = POS_W'(vx);
      row.req.speed_y = POS_W'(vy);
      row.req.size_in = HALF_W'(size);
      row.req.life_in = LIFE_W'(life);
      row.repeats     = 7'(reps);
      row.typed       = typed;
      row.typed_acc   = acc;
      row.typed_slot  = SLOT_W'(slot);
      script[script_len] = row;
      script_len++;
   endtask

   task automatic add_csr(input logic idx, input int value);
      script_row_type row;
      row         = '0;
      row.is_csr  = 1'b1;
      row.csr_idx = idx;
      row.csr_val = SCREEN_W'(value);
      script[script_len] = row;
      script_len++;
   endtask

   function automatic bit field_matches(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         return 1'b0;
      end
      return 1'b1;
   endfunction

   // response checker: every strobed transaction against the oldest expectation
   always @(posedge clock) begin : answer_check
      pool_answer_type want;
      bit              ok;
      if (!reset && rsp_strobe) begin
         if (expected_answers.size() == 0) begin
            $display("%0t ns: unexpected result, expected none, got kind %0d slot %0d",
                     $time, rsp_kind, rsp_slot);
            error_count++;
         end else begin
            want = expected_answers.pop_front();
            ok = field_matches("kind", int'(want.kind), int'(rsp_kind));
            ok = field_matches("accepted", int'(want.accepted), int'(rsp_accepted)) & ok;
            ok = field_matches("slot", int'(want.slot), int'(rsp_slot)) & ok;
            ok = field_matches("left", int'(want.left), int'(rsp_left)) & ok;
            ok = field_matches("top", int'(want.top), int'(rsp_top)) & ok;
            ok = field_matches("right", int'(want.right), int'(rsp_right)) & ok;
            ok = field_matches("bottom", int'(want.bottom), int'(rsp_bottom)) & ok;
            ok = field_matches("last", int'(want.last), int'(rsp_last)) & ok;
            if (!ok) error_count++;
         end
      end
   end

   initial begin : stimulus
      pool_answer_type typed_answer;
      int              w;
      int              h;
      int              tick_pct;
      reset       = 1'b1;
      start       = 1'b0;
      req_op      = OP_SPAWN;
      req_start_x = '0;
      req_start_y = '0;
      req_speed_x = '0;
      req_speed_y = '0;
      req_size_in = '0;
      req_life_in = '0;
      csr_we      = 1'b0;
      csr_index   = REG_SCREEN_WIDTH;
      csr_wdata   = '0;
      error_count = 0;
      gaps_on     = 1'b1;
      screen_w    = 1280;
      screen_h    = 720;
      script_len  = 0;
      for (int i = 0; i < POOL; i++) live[i] = 1'b0;

      // directed script, reset screen 1280 x 720 to start with
      add_item(OP_SPAWN, 0, 0, 0, 0, 0, 0, 1, 1, 1, 0);                // zero life
      add_item(OP_SPAWN, 20480, 11520, 0, 0, 4095, 65535, 1, 1, 1, 1); // on the corner
      add_item(OP_SPAWN, 100, 100, 16, -16, 32, 1, 1, 1, 1, 2);        // life of one
      add_item(OP_SPAWN, 32767, 32767, 0, 0, 0, 10, 1, 1, 1, 3);       // off screen
      add_item(OP_SPAWN, -32768, -32768, 32767, 32767, 1, 10, 1, 1, 1, 4);
      add_item(OP_SPAWN, 32000, 100, 32767, 0, 64, 10, 1, 1, 1, 5);    // clips high
      add_item(OP_SPAWN, -32768, -32768, -32768, -32768, 4095, 65535, 1, 1, 1, 6);
      add_item(OP_SPAWN, 20480, 11520, 1, 1, 16, 100, 1, 1, 1, 7);     // steps past edge
      add_item(OP_SPAWN, 8000, 4000, -16, 16, 2048, 4, 1, 1, 1, 8);
      add_item(OP_TICK, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0);
      add_item(OP_TICK, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0);
      add_item(OP_SPAWN, 160, 160, 0, 0, 16, 1000, 62, 0, 0, 0);       // fill the pool
      add_item(OP_SPAWN, -1, -1, -1, -1, 4095, 65535, 1, 1, 0, 0);     // pool full
      add_item(OP_TICK, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0);                 // every slot reports
      add_csr(REG_SCREEN_WIDTH, 0);
      add_csr(REG_SCREEN_HEIGHT, 0);
      add_item(OP_TICK, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0);                 // nobody survives
      add_item(OP_SPAWN, 0, 0, 0, 0, 0, 2, 1, 1, 1, 0);
      add_item(OP_TICK, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0);                 // origin on empty screen
      add_csr(REG_SCREEN_WIDTH, 2047);
      add_csr(REG_SCREEN_HEIGHT, 2047);
      add_item(OP_SPAWN, 32752, 32752, 0, 0, 4095, 5, 1, 1, 1, 1);
      add_item(OP_TICK, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0);

      repeat (10) @(negedge clock);
      reset = 1'b0;

      for (int k = 0; k < script_len; k++) begin
         if (script[k].is_csr) begin
            settle_pool();
            write_screen(script[k].csr_idx, int'(script[k].csr_val));
         end else begin
            typed_answer          = '0;
            typed_answer.kind     = KIND_SPAWN;
            typed_answer.accepted = script[k].typed_acc;
            typed_answer.slot     = script[k].typed_slot;
            typed_answer.last     = 1'b1;
            for (int j = 0; j < int'(script[k].repeats); j++)
               send_request(script[k].req, script[k].typed, typed_answer);
         end
      end

      // random phases, each under its own screen
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         settle_pool();
         case (ph)
            0: begin
               w = 1;    h = 1;    tick_pct = 25;
            end
            1: begin
               w = 2047; h = 2047; tick_pct = 10;
            end
            2: begin
               w = $urandom_range(1, 2047);
               h = $urandom_range(1, 2047);
               tick_pct = 30;
            end
            3: begin
               w = 2047; h = 1;    tick_pct = 15;
            end
            default: begin
               w = 1280; h = 720;  tick_pct = 20;
            end
         endcase
         write_screen(REG_SCREEN_WIDTH, w);
         write_screen(REG_SCREEN_HEIGHT, h);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // stretches of back-to-back transactions now and then
            if (n % 25 == 0) gaps_on = ($urandom_range(0, 3) != 0);
            send_request(random_request(tick_pct), 1'b0, '0);
         end
      end

      settle_pool();
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/core/ppa_pkg.sv
rtl/core/ppa_ram.sv
rtl/core/ppa_update.sv
rtl/core/particle_pool_ager.sv
sim/tb.sv
